// ----- hw/rtl/scfre_pkg.sv -----
// ----------------------------------------------------------------------------
// scfre_pkg
// Shared types and constants for the serial channel frame run encoder.
// ----------------------------------------------------------------------------
package scfre_pkg;

   typedef enum logic {
      REQ_STORE = 1'b0,
      REQ_FRAME = 1'b1
   } req_kind_type;

   localparam int unsigned VALUE_W    = 11;
   localparam int unsigned CLAMP_W    = 10;
   localparam int unsigned TICKS_W    = 16;
   localparam int unsigned COUNT_W    = 4;
   localparam int unsigned SYMBOL_W   = 10;   // start, 8 data, stop
   localparam int unsigned RUN_W      = 4;
   localparam int unsigned STOP_EXTRA_BITS = 10;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd6;
   localparam logic signed [VALUE_W:0] CENTRE_OFFSET = 12'sd512;
   localparam logic signed [VALUE_W:0] CLAMP_MAX     = 12'sd1023;

endpackage

// ----- hw/rtl/serial_channel_frame_run_encoder_core.sv -----
// ----------------------------------------------------------------------------
// serial_channel_frame_run_encoder_core
// Turns channel values into 8N1 serial frames reported as runs of level.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: a store word (req_type = REQ_STORE) writes one channel
//    slot and produces nothing. A frame word (REQ_FRAME) sends the next
//    frame of the cycle: header, then channel 0 .. channel_count-1.
//  - rsp_ channel: one word per run of equal line level, pulse ticks minus
//    one; rsp_last_of_frame marks the final run of a frame.
//  - csr_ channel: writes channel_count; always ready. Write only when idle.
// Flow: an accepted frame word is loaded into the run emitter registers, and
//  its first run then goes from there into the output register.
// Throughput: one run per cycle from the run emitter while rsp_stall is low;
//  a header frame has 4 runs, a channel frame up to 20. The next frame word
//  is taken in the cycle the previous frame's last run enters the output
//  register. Store words are taken in
//  any cycle.
// Reset: store cleared to zero, header frame next, channel_count = 6.
// Stall: rsp_stall holds the output register and the emitter; frame words
//  are stalled until the emitter can take them.
// ----------------------------------------------------------------------------
module serial_channel_frame_run_encoder_core #(
   parameter int unsigned MAX_CHANNELS    = 8,
   parameter int unsigned BIT_TICKS       = 16,
   parameter int unsigned FINAL_GAP_TICKS = 40000
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_type,
   input  logic [2:0]                             req_channel_index,
   input  logic signed [scfre_pkg::VALUE_W-1:0]   req_channel_value,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [scfre_pkg::TICKS_W-1:0]          rsp_pulse_ticks,
   output logic                                   rsp_line_level,
   output logic                                   rsp_last_of_frame,
   // configuration
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [scfre_pkg::COUNT_W-1:0]          csr_channel_count
);

   localparam int unsigned IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int unsigned PW = $clog2(MAX_CHANNELS + 1);
   localparam int unsigned CW = (PW > scfre_pkg::COUNT_W) ? PW : scfre_pkg::COUNT_W;
   localparam int unsigned TW = scfre_pkg::TICKS_W;
   localparam int unsigned SW = scfre_pkg::SYMBOL_W;
   localparam int unsigned RW = scfre_pkg::RUN_W;
   localparam logic [TW-1:0] BT         = TW'(BIT_TICKS);
   localparam logic [TW-1:0] STOP_EXTRA = TW'(scfre_pkg::STOP_EXTRA_BITS * BIT_TICKS);
   localparam logic [TW-1:0] FINAL_GAP  = TW'(FINAL_GAP_TICKS - 1);
   localparam logic [CW-1:0] MAX_CNT    = CW'(MAX_CHANNELS);

   // state
   logic signed [scfre_pkg::VALUE_W-1:0] store_ff [MAX_CHANNELS];
   logic [PW-1:0]                 pos_ff, pos_in;
   logic [scfre_pkg::COUNT_W-1:0] count_ff, count_in;

   // run emitter
   logic          busy_ff, busy_in;
   logic [SW-1:0] bits_ff, bits_in;
   logic [RW-1:0] nbits_ff, nbits_in;
   logic [7:0]    byte2_ff, byte2_in;
   logic          second_ff, second_in;
   logic          final_ff, final_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0] ticks_ff, ticks_in;
   logic          level_ff, level_in;
   logic          last_ff, last_in;

   // frame request decode
   logic [CW-1:0]       count_eff;
   logic [CW-1:0]       pos_ext;
   logic                send_header;
   logic [IW-1:0]       rd_idx;
   logic [IW+2:0]       wr_idx_ext;
   logic [IW-1:0]       wr_idx;
   logic                wr_en;
   logic signed [scfre_pkg::VALUE_W:0] centred;
   logic [scfre_pkg::CLAMP_W-1:0]      clamped;
   logic [7:0]          byte1;
   logic [7:0]          byte_lo;
   logic                is_final;
   logic [CW-1:0]       ch_ext;

   // handshake
   logic          load_out;
   logic          emit;
   logic          frame_end;
   logic          frame_acc;

   // run measurement
   logic [RW-1:0] run;
   logic          still;
   logic          byte_end;

   assign csr_ready = 1'b1;
   assign count_in  = (csr_valid && csr_ready) ? csr_channel_count : count_ff;

   assign count_eff   = (CW'(count_ff) > MAX_CNT) ? MAX_CNT : CW'(count_ff);
   assign pos_ext     = CW'(pos_ff);
   assign ch_ext      = pos_ext - CW'(1);
   assign send_header = (pos_ff == '0) || (ch_ext >= count_eff);
   assign rd_idx      = ch_ext[IW-1:0];
   assign is_final    = (ch_ext == (count_eff - CW'(1)));

   always_comb begin
      centred = 12'(store_ff[rd_idx]) + scfre_pkg::CENTRE_OFFSET;
      if (centred < 0) begin
         clamped = '0;
      end else if (centred > scfre_pkg::CLAMP_MAX) begin
         clamped = '1;
      end else begin
         clamped = centred[scfre_pkg::CLAMP_W-1:0];
      end
   end

   assign byte1   = send_header ? 8'h00 : 8'({ch_ext, clamped[9:8]});
   assign byte_lo = send_header ? 8'h00 : clamped[7:0];

   // measure the run starting at bit 0 of the current symbol
   always_comb begin
      run   = '0;
      still = 1'b1;
      for (int i = 0; i < SW; i++) begin
         if (still && (RW'(i) < nbits_ff) && (bits_ff[i] == bits_ff[0])) begin
            run = run + RW'(1);
         end else begin
            still = 1'b0;
         end
      end
   end

   assign byte_end  = (run == nbits_ff);
   assign frame_end = byte_end && !second_ff;
   assign load_out  = !rsp_valid_ff || !rsp_stall;
   assign emit      = busy_ff && load_out;

   assign req_stall = (req_type == scfre_pkg::REQ_FRAME) && busy_ff && !(emit && frame_end);
   assign frame_acc = req_valid && !req_stall && (req_type == scfre_pkg::REQ_FRAME);

   assign wr_idx_ext = (IW+3)'(req_channel_index);
   assign wr_idx     = wr_idx_ext[IW-1:0];
   assign wr_en      = req_valid && !req_stall && (req_type == scfre_pkg::REQ_STORE) &&
                       ((IW+3)'(req_channel_index) < (IW+3)'(MAX_CHANNELS));

   always_comb begin
      pos_in = pos_ff;
      if (frame_acc) begin
         if (send_header) begin
            pos_in = PW'(1);
         end else if (is_final) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + PW'(1);
         end
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      bits_in   = bits_ff;
      nbits_in  = nbits_ff;
      byte2_in  = byte2_ff;
      second_in = second_ff;
      final_in  = final_ff;
      if (emit) begin
         if (!byte_end) begin
            bits_in  = bits_ff >> run;
            nbits_in = nbits_ff - run;
         end else if (second_ff) begin
            bits_in   = {1'b1, byte2_ff, 1'b0};
            nbits_in  = RW'(SW);
            second_in = 1'b0;
         end else begin
            busy_in = 1'b0;
         end
      end
      if (frame_acc) begin
         busy_in   = 1'b1;
         bits_in   = {1'b1, byte1, 1'b0};
         nbits_in  = RW'(SW);
         byte2_in  = byte_lo;
         second_in = 1'b1;
         final_in  = !send_header && is_final;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      ticks_in     = ticks_ff;
      level_in     = level_ff;
      last_in      = last_ff;
      if (load_out) begin
         rsp_valid_in = busy_ff;
         ticks_in     = TW'(run) * BT - TW'(1) + (byte_end ? STOP_EXTRA : '0);
         if (frame_end && final_ff) begin
            ticks_in = FINAL_GAP;
         end
         level_in = bits_ff[0];
         last_in  = frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         count_ff     <= scfre_pkg::COUNT_RESET;
         busy_ff      <= 1'b0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            store_ff[wr_idx] <= req_channel_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      bits_ff  <= bits_in;
      nbits_ff <= nbits_in;
      byte2_ff <= byte2_in;
      final_ff <= final_in;
      ticks_ff <= ticks_in;
      level_ff <= level_in;
      last_ff  <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pulse_ticks   = ticks_ff;
   assign rsp_line_level    = level_ff;
   assign rsp_last_of_frame = last_ff;

`ifndef SYNTHESIS
   a_nbits_live : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (nbits_ff != '0))
      else $error("emitter busy with no symbol bits left");

   a_pos_range : assert property (@(posedge clock) disable iff (reset)
      CW'(pos_ff) <= MAX_CNT)
      else $error("frame position beyond channel store");

   a_symbol_frame : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (nbits_ff == RW'(SW))) |-> (!bits_ff[0] && bits_ff[SW-1]))
      else $error("fresh symbol lacks start or stop bit");

   a_frame_loads : assert property (@(posedge clock) disable iff (reset)
      frame_acc |=> (busy_ff && second_ff))
      else $error("accepted frame word did not load the emitter");
`endif

endmodule
